FILE: rtl/core/iefr_pkg.sv
// ----------------------------------------------------------------------------
// iefr_pkg
// Shared types, constants and the verdict function of the echo reply filter.
// ----------------------------------------------------------------------------
package iefr_pkg;

   // frame length limit; the byte position saturates here
   localparam int MAX_FRAME_BYTES = 2047;
   localparam int POS_W           = $clog2(MAX_FRAME_BYTES + 1);

   localparam int ETH_HDR_LEN     = 14;
   localparam int IP_MIN_HDR_LEN  = 20;
   localparam int ICMP_HDR_LEN    = 8;
   localparam int MIN_IHL_WORDS   = 5;

   localparam logic [15:0] ETYPE_ARP            = 16'h0806;
   localparam logic [15:0] ETYPE_IPV4           = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP           = 8'd1;
   localparam logic [7:0]  ICMP_TYPE_ECHO_REPLY = 8'd0;
   localparam logic [3:0]  IP_VERSION_4         = 4'd4;
   localparam logic [3:0]  IHL_MASK             = 4'h0F;

   // byte offsets within the frame
   localparam int POS_ETYPE_HI = 12;
   localparam int POS_ETYPE_LO = 13;
   localparam int POS_VER_IHL  = 14;
   localparam int POS_PROTO    = 23;
   localparam int POS_SRC_END  = 29;
   localparam int POS_DST_END  = 33;

   // offsets within the icmp header
   localparam int OFF_TYPE   = 0;
   localparam int OFF_CODE   = 1;
   localparam int OFF_ID_END = 5;
   localparam int OFF_SEQ_END = 7;

   localparam logic [15:0] ECHO_ID_RESET = 16'h4A50;

   typedef logic [POS_W-1:0] pos_type;

   typedef enum logic [1:0] {
      CSR_LOCAL_IP     = 2'd0,
      CSR_PEER_IP      = 2'd1,
      CSR_ECHO_ID      = 2'd2,
      CSR_EXPECTED_SEQ = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      VERDICT_MATCH   = 4'd0,
      VERDICT_ARP     = 4'd1,
      VERDICT_NOT_IP  = 4'd2,
      VERDICT_SHORT   = 4'd3,
      VERDICT_VERSION = 4'd4,
      VERDICT_PROTO   = 4'd5,
      VERDICT_SRC     = 4'd6,
      VERDICT_DST     = 4'd7,
      VERDICT_IHL     = 4'd8,
      VERDICT_TYPE    = 4'd9,
      VERDICT_CODE    = 4'd10,
      VERDICT_ID      = 4'd11,
      VERDICT_SEQ     = 4'd12
   } verdict_type;

   typedef struct packed {
      logic version;
      logic proto;
      logic src;
      logic dst;
      logic icmp_type;
      logic code;
      logic id;
      logic seq;
   } flags_type;

   typedef struct packed {
      pos_type     pos;
      logic [15:0] ether_type;
      logic [3:0]  header_words;
      flags_type   flags;
      logic [31:0] field_shift;
   } frame_state_type;

   typedef struct packed {
      logic [31:0] local_ip;
      logic [31:0] peer_ip;
      logic [15:0] echo_id;
      logic [15:0] expected_seq;
   } csr_type;

   function automatic verdict_type decide(input frame_state_type st);
      pos_type     icmp_end;
      verdict_type v;
      icmp_end = pos_type'(ETH_HDR_LEN + ICMP_HDR_LEN) + pos_type'({st.header_words, 2'b00});
      if (st.pos < pos_type'(ETH_HDR_LEN))                                   v = VERDICT_SHORT;
      else if (st.ether_type == ETYPE_ARP)                                   v = VERDICT_ARP;
      else if (st.ether_type != ETYPE_IPV4)                                  v = VERDICT_NOT_IP;
      else if (st.pos < pos_type'(ETH_HDR_LEN + IP_MIN_HDR_LEN + ICMP_HDR_LEN))
                                                                             v = VERDICT_SHORT;
      else if (st.flags.version)                                             v = VERDICT_VERSION;
      else if (st.flags.proto)                                               v = VERDICT_PROTO;
      else if (st.flags.src)                                                 v = VERDICT_SRC;
      else if (st.flags.dst)                                                 v = VERDICT_DST;
      else if (st.header_words < 4'(MIN_IHL_WORDS))                          v = VERDICT_IHL;
      else if (st.pos < icmp_end)                                            v = VERDICT_SHORT;
      else if (st.flags.icmp_type)                                           v = VERDICT_TYPE;
      else if (st.flags.code)                                                v = VERDICT_CODE;
      else if (st.flags.id)                                                  v = VERDICT_ID;
      else if (st.flags.seq)                                                 v = VERDICT_SEQ;
      else                                                                   v = VERDICT_MATCH;
      return v;
   endfunction

endpackage

FILE: rtl/core/iefr_examine.sv
// ----------------------------------------------------------------------------
// iefr_examine
// Per-byte header parser: works out the frame state after one more byte.
// ----------------------------------------------------------------------------
module iefr_examine (
   input  iefr_pkg::frame_state_type cur,
   input  logic [7:0]                frame_byte,
   input  iefr_pkg::csr_type         csr,
   output iefr_pkg::frame_state_type nxt
);

   iefr_pkg::pos_type base;
   iefr_pkg::pos_type off;
   logic [31:0]       shift_in;

   assign shift_in = {cur.field_shift[23:0], frame_byte};
   assign base     = iefr_pkg::pos_type'(iefr_pkg::ETH_HDR_LEN)
                     + iefr_pkg::pos_type'({cur.header_words, 2'b00});
   assign off      = cur.pos - base;

   always_comb begin
      nxt = cur;
      // bytes past the length limit are not looked at
      if (cur.pos < iefr_pkg::pos_type'(iefr_pkg::MAX_FRAME_BYTES)) begin
         nxt.pos         = cur.pos + iefr_pkg::pos_type'(1);
         nxt.field_shift = shift_in;
         if (cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_ETYPE_HI) ||
             cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_ETYPE_LO)) begin
            nxt.ether_type = {cur.ether_type[7:0], frame_byte};
         end
         if (cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_VER_IHL)) begin
            nxt.header_words = frame_byte[3:0] & iefr_pkg::IHL_MASK;
            if (frame_byte[7:4] != iefr_pkg::IP_VERSION_4) nxt.flags.version = 1'b1;
         end
         if (cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_PROTO) &&
             frame_byte != iefr_pkg::PROTO_ICMP) begin
            nxt.flags.proto = 1'b1;
         end
         if (cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_SRC_END) &&
             shift_in != csr.peer_ip) begin
            nxt.flags.src = 1'b1;
         end
         if (cur.pos == iefr_pkg::pos_type'(iefr_pkg::POS_DST_END) &&
             shift_in != csr.local_ip) begin
            nxt.flags.dst = 1'b1;
         end
         // icmp header sits right after the ip header, wherever ihl puts it
         if (cur.pos > iefr_pkg::pos_type'(iefr_pkg::ETH_HDR_LEN) && cur.pos >= base) begin
            if (off == iefr_pkg::pos_type'(iefr_pkg::OFF_TYPE) &&
                frame_byte != iefr_pkg::ICMP_TYPE_ECHO_REPLY) begin
               nxt.flags.icmp_type = 1'b1;
            end
            if (off == iefr_pkg::pos_type'(iefr_pkg::OFF_CODE) && frame_byte != 8'd0) begin
               nxt.flags.code = 1'b1;
            end
            if (off == iefr_pkg::pos_type'(iefr_pkg::OFF_ID_END) &&
                shift_in[15:0] != csr.echo_id) begin
               nxt.flags.id = 1'b1;
            end
            if (off == iefr_pkg::pos_type'(iefr_pkg::OFF_SEQ_END) &&
                shift_in[15:0] != csr.expected_seq) begin
               nxt.flags.seq = 1'b1;
            end
         end
      end
   end

endmodule

FILE: rtl/core/icmp_echo_reply_filter_core.sv
// ----------------------------------------------------------------------------
// icmp_echo_reply_filter_core
// Classifies a received frame as a matching ICMP echo reply or names the
// first check it fails.
// ----------------------------------------------------------------------------
// the verdict and rsp_valid are registered when the last byte is accepted
// throughput: one byte per cycle, set by the single-pass parser and result register
// a last byte is held off only while a previous verdict is still stalled
// reset: registers but the verdict return to reset values; frame state is cleared
// ----------------------------------------------------------------------------
module icmp_echo_reply_filter_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_verdict,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   iefr_pkg::csr_type         csr_ff;
   iefr_pkg::frame_state_type frame_ff;
   iefr_pkg::frame_state_type frame_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   iefr_pkg::verdict_type     verdict_ff;
   logic                      req_accept;

   iefr_examine u_examine (
      .cur        (frame_ff),
      .frame_byte (req_frame_byte),
      .csr        (csr_ff),
      .nxt        (frame_in)
   );

   // a byte that ends a frame needs room in the result register
   assign req_stall    = req_last_byte & rsp_valid_ff & rsp_stall;
   assign req_accept   = req_valid & ~req_stall;
   assign rsp_valid_in = (rsp_valid_ff & rsp_stall) | (req_accept & req_last_byte);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.local_ip     <= '0;
         csr_ff.peer_ip      <= '0;
         csr_ff.echo_id      <= iefr_pkg::ECHO_ID_RESET;
         csr_ff.expected_seq <= '0;
      end else if (csr_write_enable) begin
         case (iefr_pkg::csr_index_type'(csr_index))
            iefr_pkg::CSR_LOCAL_IP:     csr_ff.local_ip     <= csr_write_data;
            iefr_pkg::CSR_PEER_IP:      csr_ff.peer_ip      <= csr_write_data;
            iefr_pkg::CSR_ECHO_ID:      csr_ff.echo_id      <= csr_write_data[15:0];
            iefr_pkg::CSR_EXPECTED_SEQ: csr_ff.expected_seq <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            if (req_last_byte) frame_ff <= '0;
            else               frame_ff <= frame_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_last_byte) begin
         verdict_ff <= iefr_pkg::decide(frame_in);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_verdict = verdict_ff;

endmodule
